// ===== sv/avdd_pkg.sv =====
// ============================================================================
// avdd_pkg
// Shared widths, constants, segment code table and digit helpers for the
// averaging voltmeter digit driver.
// ============================================================================
package avdd_pkg;

    localparam int SAMPLE_W = 10;
    localparam int REF_W    = 7;
    localparam int SUM_W    = 16;
    localparam int AVG_W    = 10;
    localparam int SEG_W    = 12;
    localparam int DIGIT_W  = 4;
    localparam int TENTHS_W = 7;

    localparam int SPR_DEFAULT = 10;
    localparam int AFS_DEFAULT = 1023;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [REF_W-1:0]    REF_RESET  = 7'd33;
    localparam logic [TENTHS_W-1:0] TENTHS_MAX = 7'd99;
    localparam logic [SEG_W-1:0]    DP_BIT     = 12'h800;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } avdd_push_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] ip;
        logic [DIGIT_W-1:0] fp;
    } avdd_digits_t;

    function automatic logic [SEG_W-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] p;
        begin
            case (d)
                4'd0:    p = 12'h3D2;
                4'd1:    p = 12'h050;
                4'd2:    p = 12'h592;
                4'd3:    p = 12'h4D2;
                4'd4:    p = 12'h650;
                4'd5:    p = 12'h6C2;
                4'd6:    p = 12'h7C2;
                4'd7:    p = 12'h052;
                4'd8:    p = 12'h7D2;
                4'd9:    p = 12'h6D2;
                default: p = '0;
            endcase
            return p;
        end
    endfunction

    // divide by ten via reciprocal, exact for 0..99
    function automatic avdd_digits_t split_tenths(input logic [TENTHS_W-1:0] t);
        logic [17:0]         prod;
        logic [TENTHS_W-1:0] tens;
        avdd_digits_t        r;
        begin
            prod = {11'b0, t} * 18'd205;
            r.ip = prod[14:11];
            tens = {3'b0, r.ip} * 7'd10;
            r.fp = 4'(t - tens);
            return r;
        end
    endfunction

endpackage

// ===== sv/avdd_front.sv =====
// ============================================================================
// avdd_front
// Sample intake: accumulates samples and hands each finished block sum
// to the queue.
// ============================================================================
module avdd_front
    import avdd_pkg::*;
#(
    parameter int SAMPLES_PER_READING = SPR_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                q_full,
    output avdd_push_t          push
);

    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_READING - 1);

    logic [SUM_W-1:0] sum_reg,  sum_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic             last;
    logic             accept;
    logic [SUM_W-1:0] sum_total;

    assign last      = (seen_reg == LAST_CNT);
    assign in_ready  = !q_full || !last;
    assign accept    = in_valid && in_ready;
    assign sum_total = sum_reg + {{(SUM_W-SAMPLE_W){1'b0}}, sample};

    assign push.valid = accept && last;
    assign push.sum   = sum_total;

    always_comb
    begin
        sum_next  = sum_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (last)
            begin
                sum_next  = '0;
                seen_next = '0;
            end
            else
            begin
                sum_next  = sum_total;
                seen_next = seen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            seen_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== sv/avdd_queue.sv =====
// ============================================================================
// avdd_queue
// Short queue of finished block sums between intake and the scaling pipe.
// ============================================================================
module avdd_queue
    import avdd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  avdd_push_t       push,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output logic [SUM_W-1:0] head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

    logic [SUM_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("queue overflow");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

// ===== sv/avdd_back.sv =====
// ============================================================================
// avdd_back
// Scaling pipe: block mean, conversion to tenths of a volt, digit split,
// digit multiplexing and segment image, with the reference register.
// ============================================================================
module avdd_back
    import avdd_pkg::*;
#(
    parameter int SAMPLES_PER_READING = SPR_DEFAULT,
    parameter int ADC_FULL_SCALE      = AFS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [REF_W-1:0]    cfg_wdata,
    input  logic                q_empty,
    input  logic [SUM_W-1:0]    q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SEG_W-1:0]    segment_bits,
    output logic                fraction_digit_on,
    output logic [DIGIT_W-1:0]  integer_digit,
    output logic [DIGIT_W-1:0]  fraction_digit,
    output logic [AVG_W-1:0]    average_code
);

    localparam int PROD_W = REF_W + AVG_W;
    localparam int SPR_W  = 7;
    localparam int AFS_W  = 12;
    localparam int P1_W   = 2 * SUM_W + 1;
    localparam int Q1_W   = SUM_W + 1;
    localparam int X1_W   = Q1_W + SPR_W;
    localparam int P2_W   = 2 * PROD_W + 1;
    localparam int Q2_W   = PROD_W + 1;
    localparam int X2_W   = Q2_W + AFS_W;

    localparam logic [SUM_W:0]     M1    = (SUM_W+1)'((1 << SUM_W) / SAMPLES_PER_READING);
    localparam logic [PROD_W:0]    M2    = (PROD_W+1)'((1 << PROD_W) / ADC_FULL_SCALE);
    localparam logic [SPR_W-1:0]   SPR_C = SPR_W'(SAMPLES_PER_READING);
    localparam logic [AFS_W-1:0]   AFS_C = AFS_W'(ADC_FULL_SCALE);

    logic                 adv;
    logic [REF_W-1:0]     ref_reg;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SUM_W-1:0]     s1_sum_reg;
    logic [P1_W-1:0]      s1_p_reg;
    logic [AVG_W-1:0]     s2_avg_reg;
    logic [AVG_W-1:0]     s3_avg_reg;
    logic [PROD_W-1:0]    s3_prod_reg;
    logic [AVG_W-1:0]     s4_avg_reg;
    logic [PROD_W-1:0]    s4_prod_reg;
    logic [P2_W-1:0]      s4_p_reg;
    logic [AVG_W-1:0]     s5_avg_reg;
    logic [TENTHS_W-1:0]  s5_tenths_reg;

    logic                 out_valid_reg;
    logic                 showing_reg;
    logic [SEG_W-1:0]     seg_reg;
    logic [DIGIT_W-1:0]   ip_reg;
    logic [DIGIT_W-1:0]   fp_reg;
    logic [AVG_W-1:0]     avg_reg;

    logic [Q1_W-1:0]      q1;
    logic [X1_W-1:0]      q1x;
    logic [X1_W-1:0]      r1;
    logic [AVG_W-1:0]     s2_avg_next;
    logic [Q2_W-1:0]      q2;
    logic [X2_W-1:0]      q2x;
    logic [X2_W-1:0]      r2;
    logic [Q2_W:0]        t_full;
    logic [TENTHS_W-1:0]  s5_tenths_next;
    avdd_digits_t         digits;
    logic                 showing_next;
    logic [SEG_W-1:0]     seg_next;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    // block mean: reciprocal estimate then one correction
    assign q1  = s1_p_reg[P1_W-1:SUM_W];
    assign q1x = {{SPR_W{1'b0}}, q1} * {{Q1_W{1'b0}}, SPR_C};
    assign r1  = {{(X1_W-SUM_W){1'b0}}, s1_sum_reg} - q1x;
    assign s2_avg_next = q1[AVG_W-1:0]
                       + {{(AVG_W-1){1'b0}}, (r1 >= {{Q1_W{1'b0}}, SPR_C})};

    // tenths of a volt, same scheme, then clamp
    assign q2  = s4_p_reg[P2_W-1:PROD_W];
    assign q2x = {{AFS_W{1'b0}}, q2} * {{Q2_W{1'b0}}, AFS_C};
    assign r2  = {{(X2_W-PROD_W){1'b0}}, s4_prod_reg} - q2x;
    assign t_full = {1'b0, q2} + {{Q2_W{1'b0}}, (r2 >= {{Q2_W{1'b0}}, AFS_C})};
    assign s5_tenths_next = (t_full > {{(Q2_W+1-TENTHS_W){1'b0}}, TENTHS_MAX})
                          ? TENTHS_MAX : t_full[TENTHS_W-1:0];

    // digit mux
    assign digits       = split_tenths(s5_tenths_reg);
    assign showing_next = ~showing_reg;
    assign seg_next     = showing_next ? digit_pattern(digits.fp)
                                       : (digit_pattern(digits.ip) | DP_BIT);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sum_reg    <= q_head;
            s1_p_reg      <= {{(SUM_W+1){1'b0}}, q_head} * {{SUM_W{1'b0}}, M1};
            s2_avg_reg    <= s2_avg_next;
            s3_avg_reg    <= s2_avg_reg;
            s3_prod_reg   <= {{REF_W{1'b0}}, s2_avg_reg} * {{AVG_W{1'b0}}, ref_reg};
            s4_avg_reg    <= s3_avg_reg;
            s4_prod_reg   <= s3_prod_reg;
            s4_p_reg      <= {{(PROD_W+1){1'b0}}, s3_prod_reg} * {{PROD_W{1'b0}}, M2};
            s5_avg_reg    <= s4_avg_reg;
            s5_tenths_reg <= s5_tenths_next;
            if (v5_reg)
            begin
                seg_reg <= seg_next;
                ip_reg  <= digits.ip;
                fp_reg  <= digits.fp;
                avg_reg <= s5_avg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= REF_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            showing_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ref_reg <= cfg_wdata;
            if (adv)
            begin
                v1_reg        <= !q_empty;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                out_valid_reg <= v5_reg;
                if (v5_reg)
                    showing_reg <= showing_next;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign segment_bits      = seg_reg;
    assign fraction_digit_on = showing_reg;
    assign integer_digit     = ip_reg;
    assign fraction_digit    = fp_reg;
    assign average_code      = avg_reg;

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (integer_digit <= 4'd9) && (fraction_digit <= 4'd9))
        else $error("digit out of range");

    a_dp_on_integer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (segment_bits[11] == !fraction_digit_on))
        else $error("decimal point on wrong digit");

    a_digit_alternates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && v5_reg |=> fraction_digit_on != $past(fraction_digit_on))
        else $error("lit digit did not alternate");

endmodule

// ===== sv/averaging_voltmeter_digit_driver_unit.sv =====
// ============================================================================
// averaging_voltmeter_digit_driver_unit
// Averaging voltmeter with a two-digit multiplexed seven-segment driver.
// ============================================================================
// Takes one sample per clock, sustained, with out_ready high. Samples are
// summed in the intake over blocks of SAMPLES_PER_READING; the last sample of
// a block pushes the sum into a two-entry queue, and a six-stage scaling pipe
// (mean, reference multiply, full-scale divide, digit split and segment image)
// delivers the result. The intake only stalls on a block-ending sample when
// the queue is full, which happens only while the output side holds
// out_ready low. reference_tenths is written through cfg_we/cfg_wdata and
// must only change while no block is in flight.
// ============================================================================
module averaging_voltmeter_digit_driver_unit
    import avdd_pkg::*;
#(
    parameter int SAMPLES_PER_READING = SPR_DEFAULT,
    parameter int ADC_FULL_SCALE      = AFS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [REF_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SEG_W-1:0]    segment_bits,
    output logic                fraction_digit_on,
    output logic [DIGIT_W-1:0]  integer_digit,
    output logic [DIGIT_W-1:0]  fraction_digit,
    output logic [AVG_W-1:0]    average_code
);

    avdd_push_t       push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [SUM_W-1:0] q_head;

    avdd_front #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .q_full   (q_full),
        .push     (push)
    );

    avdd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (q_head)
    );

    avdd_back #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING),
        .ADC_FULL_SCALE      (ADC_FULL_SCALE)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .q_empty           (q_empty),
        .q_head            (q_head),
        .q_pop             (q_pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .segment_bits      (segment_bits),
        .fraction_digit_on (fraction_digit_on),
        .integer_digit     (integer_digit),
        .fraction_digit    (fraction_digit),
        .average_code      (average_code)
    );

endmodule

// ===== bench/tb.sv =====
// ============================================================================
// tb
// Testbench for averaging_voltmeter_digit_driver_unit. Feeds blocks of ADC
// samples over several reference settings, predicts each finished reading
// (mean code, volt digits, lit digit and segment image) and compares every
// result item against the oldest pending prediction, under random
// sender bursts, receiver stalls and one long output hold-off.
// ============================================================================
module tb
    import avdd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_LEN  = SPR_DEFAULT;
    localparam int FULL_SCALE = AFS_DEFAULT;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 9;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam logic [SEG_W-1:0] SEG_CODES [10] = '{
        12'h3D2, 12'h050, 12'h592, 12'h4D2, 12'h650,
        12'h6C2, 12'h7C2, 12'h052, 12'h7D2, 12'h6D2
    };

    typedef struct {
        logic [SEG_W-1:0]   seg;
        logic               frac_on;
        logic [DIGIT_W-1:0] int_dig;
        logic [DIGIT_W-1:0] frac_dig;
        logic [AVG_W-1:0]   avg;
    } reading_t;

    class reading_scoreboard;
        reading_t         expected_readings[$];
        logic [REF_W-1:0] ref_tenths;
        logic [SUM_W-1:0] acc_sum;
        int unsigned      acc_count;
        logic             showing_frac;
        int unsigned      errors;

        function new();
            ref_tenths   = REF_RESET;
            acc_sum      = '0;
            acc_count    = 0;
            showing_frac = 1'b0;
            errors       = 0;
        endfunction

        function void set_reference(logic [REF_W-1:0] v);
            ref_tenths = v;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            reading_t    r;
            int unsigned tenths;
            acc_sum = acc_sum + SUM_W'(s);
            if (acc_count + 1 < BLOCK_LEN)
            begin
                acc_count++;
                return;
            end
            r.avg     = AVG_W'(acc_sum / BLOCK_LEN);
            acc_sum   = '0;
            acc_count = 0;
            tenths = (int'(ref_tenths) * int'(r.avg)) / FULL_SCALE;
            if (tenths > 99)
                tenths = 99;
            r.int_dig    = DIGIT_W'(tenths / 10);
            r.frac_dig   = DIGIT_W'(tenths % 10);
            showing_frac = ~showing_frac;
            r.frac_on    = showing_frac;
            if (showing_frac)
                r.seg = SEG_CODES[r.frac_dig];
            else
                r.seg = SEG_CODES[r.int_dig] | DP_BIT;
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                         act_v);
            end
        endfunction

        function void check_result(reading_t act);
            reading_t exp_r;
            if (expected_readings.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual avg %0d", $time,
                         act.avg);
                return;
            end
            exp_r = expected_readings.pop_front();
            compare_field("segment_bits", exp_r.seg, act.seg);
            compare_field("fraction_digit_on", exp_r.frac_on, act.frac_on);
            compare_field("integer_digit", exp_r.int_dig, act.int_dig);
            compare_field("fraction_digit", exp_r.frac_dig, act.frac_dig);
            compare_field("average_code", exp_r.avg, act.avg);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [REF_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample;
    logic                out_valid;
    logic                out_ready;
    logic [SEG_W-1:0]    segment_bits;
    logic                fraction_digit_on;
    logic [DIGIT_W-1:0]  integer_digit;
    logic [DIGIT_W-1:0]  fraction_digit;
    logic [AVG_W-1:0]    average_code;

    reading_scoreboard sb;
    int  ready_mode;
    bit  long_hold_req;
    bit  sender_gaps;
    int  burst_left;

    averaging_voltmeter_digit_driver_unit DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample            (sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .segment_bits      (segment_bits),
        .fraction_digit_on (fraction_digit_on),
        .integer_digit     (integer_digit),
        .fraction_digit    (fraction_digit),
        .average_code      (average_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("averaging_voltmeter_digit_driver_unit verification failed");
        $finish;
    end

    // accepted items on both channels
    initial
    begin
        reading_t act;
        forever
        begin
            @(posedge clk);
            if (rst_n && in_valid && in_ready)
                sb.note_sample(sample);
            if (rst_n && out_valid && out_ready)
            begin
                act.seg      = segment_bits;
                act.frac_on  = fraction_digit_on;
                act.int_dig  = integer_digit;
                act.frac_dig = fraction_digit;
                act.avg      = average_code;
                sb.check_result(act);
            end
        end
    end

    // receiver stall patterns
    initial
    begin
        int unsigned tick;
        tick = 0;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            tick++;
            case (ready_mode)
                0: out_ready = 1'b1;
                1: out_ready = ($urandom_range(0, 3) != 0);
                2: out_ready = 1'($urandom_range(0, 1));
                default: out_ready = ((tick % 7) >= 3);
            endcase
        end
    end

    // all tasks start and end just after a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        if (sender_gaps && burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        in_valid = 1'b1;
        sample = v;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
    endtask

    task automatic write_reference(input logic [REF_W-1:0] v);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(posedge clk);
        sb.set_reference(v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.expected_readings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(1000, 1023));
            3: return SAMPLE_W'($urandom_range(0, 24));
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    initial
    begin
        logic [REF_W-1:0]    ref_table [6] = '{7'd127, 7'd0, 7'd1, 7'd99, 7'd64, 7'd33};
        logic [SAMPLE_W-1:0] mixed_block [BLOCK_LEN] = '{
            10'h000, 10'h155, 10'h2AA, 10'h001, 10'h3FE,
            10'h200, 10'h100, 10'h3FF, 10'h000, 10'h000
        };
        logic [REF_W-1:0]    ref_val;
        logic [SAMPLE_W-1:0] block_val;
        bit                  const_block;

        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        sample = '0;
        ready_mode = 0;
        long_hold_req = 1'b0;
        sender_gaps = 1'b0;
        burst_left = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset reference: full-scale block, then a mix of extreme codes
        repeat (BLOCK_LEN) send_sample('1);
        foreach (mixed_block[i])
            send_sample(mixed_block[i]);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            ref_val = (p < 6) ? ref_table[p] : REF_W'($urandom_range(0, 127));
            write_reference(ref_val);
            sender_gaps = (p % 3 != 0);
            ready_mode = p % 4;
            burst_left = 0;
            const_block = 1'b1;
            block_val = '1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % BLOCK_LEN == 0 && i != 0)
                begin
                    const_block = ($urandom_range(0, 3) == 0);
                    block_val = pick_sample();
                end
                if (p == 2 && i == 50)
                    long_hold_req = 1'b1;
                send_sample(const_block ? block_val : pick_sample());
            end
            wait_drained();
        end

        if (sb.expected_readings.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected result items never arrived", $time,
                     sb.expected_readings.size());
        end
        if (sb.errors == 0)
            $display("averaging_voltmeter_digit_driver_unit verification clean");
        else
            $display("averaging_voltmeter_digit_driver_unit verification failed");
        $finish;
    end

endmodule
